[src/htfc_pkg.sv]
// shared constants, types and the crc helper for the humidity/temperature frame converter
package htfc_pkg;

  localparam int NumW     = 26;  // magnitude of (cap - cal_low) * 600
  localparam int DenW     = 16;  // magnitude of cal_high - cal_low
  localparam int DivSteps = NumW;
  localparam int TempW    = 12;
  localparam int CorrW    = 10;
  localparam int HumW     = 10;
  localparam int SumW     = 28;
  localparam int AddrW    = 3;
  localparam int DataW    = 32;

  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hFF;

  typedef enum logic {
    RegCalHigh = 1'b0,
    RegCalLow  = 1'b1
  } reg_idx_e;

  // sideband carried alongside the divider
  typedef struct packed {
    logic                    t_ok;
    logic                    h_ok;
    logic                    cal_eq;
    logic                    q_neg;
    logic signed [TempW-1:0] temperature;
    logic signed [CorrW-1:0] corr;
  } side_t;

  typedef struct packed {
    logic                    temp_valid;
    logic signed [TempW-1:0] temperature;
    logic                    hum_valid;
    logic [HumW-1:0]         humidity;
    logic                    crc_error;
    logic                    cal_error;
  } res_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[src/humidity_temp_frame_convert_unit.sv]
// humidity/temperature frame converter: crc check, temperature scaling, pipelined humidity divide
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  frame   | in_valid_i, in_ready_o, temp_*_i, hum_*_i    | in
//  result  | out_valid_o, out_ready_i, result fields _o   | out
//  config  | psel, penable, pwrite, paddr, pwdata, prdata | apb
//
// one frame a cycle while in_ready_o is high; a result passes from its frame beat through
// the crc and multiply registers, the 26 restoring-divide stages, the final and output registers.
// reset clears the valid bits, the skid flag and both calibration words.
// the whole pipeline moves on one enable; when the output register is held a
// single skid register catches the next result and only then in_ready_o drops.
module humidity_temp_frame_convert_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    temp_msb_i,
  input  logic [7:0]                    temp_lsb_i,
  input  logic [7:0]                    temp_crc_i,
  input  logic [7:0]                    hum_msb_i,
  input  logic [7:0]                    hum_lsb_i,
  input  logic [7:0]                    hum_crc_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          temp_valid_o,
  output logic signed [htfc_pkg::TempW-1:0] temperature_o,
  output logic                          hum_valid_o,
  output logic [htfc_pkg::HumW-1:0]     humidity_o,
  output logic                          crc_error_o,
  output logic                          cal_error_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [htfc_pkg::AddrW-1:0]    paddr,
  input  logic [htfc_pkg::DataW-1:0]    pwdata,
  output logic [htfc_pkg::DataW-1:0]    prdata,
  output logic                          pready
);
  import htfc_pkg::*;

  localparam int NStg = DivSteps + 3;  // s1, s2, divide stages, final

  // configuration
  logic [15:0] cal_high_q, cal_low_q;
  logic        cfg_wr;

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_high_q <= '0;
      cal_low_q  <= '0;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr[2]))
        RegCalHigh: cal_high_q <= pwdata[15:0];
        RegCalLow:  cal_low_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[2]))
      RegCalHigh: prdata = DataW'(cal_high_q);
      RegCalLow:  prdata = DataW'(cal_low_q);
      default:    prdata = '0;
    endcase
  end

  // pipeline control
  logic            en;
  logic            skid_full_q;
  logic [NStg-1:0] v_q;

  assign en         = !skid_full_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NStg-2:0], in_valid_i};
    end
  end

  // stage 1: first crc byte, calibration differences as sign and magnitude
  logic [7:0]      s1_tc_q, s1_hc_q, s1_tlsb_q, s1_hlsb_q, s1_tcrc_q, s1_hcrc_q, s1_tmsb_q;
  logic [DenW-1:0] s1_diff_q, s1_den_q;
  logic            s1_diff_neg_q, s1_den_neg_q, s1_cal_eq_q;
  logic [DenW:0]   diff_d, den_d, diff_abs, den_abs;

  always_comb begin
    diff_d   = {1'b0, hum_msb_i, hum_lsb_i} - {1'b0, cal_low_q};
    den_d    = {1'b0, cal_high_q} - {1'b0, cal_low_q};
    diff_abs = diff_d[DenW] ? ((DenW+1)'(0) - diff_d) : diff_d;
    den_abs  = den_d[DenW] ? ((DenW+1)'(0) - den_d) : den_d;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_tc_q       <= crc8_byte(CrcInit, temp_msb_i);
      s1_hc_q       <= crc8_byte(CrcInit, hum_msb_i);
      s1_tmsb_q     <= temp_msb_i;
      s1_tlsb_q     <= temp_lsb_i;
      s1_hlsb_q     <= hum_lsb_i;
      s1_tcrc_q     <= temp_crc_i;
      s1_hcrc_q     <= hum_crc_i;
      s1_diff_q     <= diff_abs[DenW-1:0];
      s1_den_q      <= den_abs[DenW-1:0];
      s1_diff_neg_q <= diff_d[DenW];
      s1_den_neg_q  <= den_d[DenW];
      s1_cal_eq_q   <= (cal_high_q == cal_low_q);
    end
  end

  // stage 2: crc compare, temperature scaling, numerator multiply
  logic signed [15:0] traw;
  logic signed [19:0] tnum, tnum_adj;
  logic [NumW-1:0]    s2_num_q;
  logic [DenW-1:0]    s2_den_q;
  side_t              s2_side_q;

  always_comb begin
    traw     = $signed({s1_tmsb_q, s1_tlsb_q});
    tnum     = 20'sd102400 + 20'(traw) * 20'sd10;
    // round toward zero before the arithmetic shift
    tnum_adj = tnum[19] ? (tnum + 20'sd255) : tnum;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_num_q              <= NumW'(s1_diff_q) * NumW'(600);
      s2_den_q              <= s1_den_q;
      s2_side_q.t_ok        <= (crc8_byte(s1_tc_q, s1_tlsb_q) == s1_tcrc_q);
      s2_side_q.h_ok        <= (crc8_byte(s1_hc_q, s1_hlsb_q) == s1_hcrc_q);
      s2_side_q.cal_eq      <= s1_cal_eq_q;
      s2_side_q.q_neg       <= s1_diff_neg_q ^ s1_den_neg_q;
      s2_side_q.temperature <= tnum_adj[19:8];
      s2_side_q.corr        <= '0;
    end
  end

  // temperature correction 25 * (t - 250) / 100 == (t - 250) / 4, toward zero
  logic signed [TempW-1:0] tcx, tcx_adj;
  side_t                   side0;

  always_comb begin
    tcx        = s2_side_q.temperature - TempW'(250);
    tcx_adj    = tcx[TempW-1] ? (tcx + TempW'(3)) : tcx;
    side0      = s2_side_q;
    side0.corr = tcx_adj[TempW-1:2];
  end

  // restoring divider, one quotient bit per stage; quotient shifts into nq
  logic [DenW-1:0] div_rem_q [DivSteps];
  logic [NumW-1:0] div_nq_q  [DivSteps];
  logic [DenW-1:0] div_den_q [DivSteps];
  side_t           div_side_q[DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    logic [DenW-1:0] rem_in;
    logic [NumW-1:0] nq_in;
    logic [DenW-1:0] den_in;
    side_t           side_in;
    logic [DenW:0]   trial, diff;
    logic            fits;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign nq_in   = s2_num_q;
      assign den_in  = s2_den_q;
      assign side_in = side0;
    end else begin : g_next
      assign rem_in  = div_rem_q[k-1];
      assign nq_in   = div_nq_q[k-1];
      assign den_in  = div_den_q[k-1];
      assign side_in = div_side_q[k-1];
    end

    assign trial = {rem_in, nq_in[NumW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign fits  = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en) begin
        div_rem_q[k]  <= fits ? diff[DenW-1:0] : trial[DenW-1:0];
        div_nq_q[k]   <= {nq_in[NumW-2:0], fits};
        div_den_q[k]  <= den_in;
        div_side_q[k] <= side_in;
      end
    end
  end

  // final stage: sign, offset, correction and clamp
  side_t                  fs;
  logic signed [SumW-1:0] qs, hsum;
  logic [HumW-1:0]        hclamp;
  logic                   hum_ok;
  res_t                   fin_d, fin_q;

  always_comb begin
    fs     = div_side_q[DivSteps-1];
    qs     = $signed(SumW'(div_nq_q[DivSteps-1]));
    if (fs.q_neg) begin
      qs = -qs;
    end
    hsum   = qs + SumW'(300) + SumW'(fs.corr);
    if (hsum > SumW'(1000)) begin
      hclamp = HumW'(999);
    end else if (hsum < 0) begin
      hclamp = '0;
    end else begin
      hclamp = hsum[HumW-1:0];
    end
    hum_ok            = fs.t_ok & fs.h_ok & !fs.cal_eq;
    fin_d.temp_valid  = fs.t_ok;
    fin_d.temperature = fs.t_ok ? fs.temperature : '0;
    fin_d.hum_valid   = hum_ok;
    fin_d.humidity    = hum_ok ? hclamp : '0;
    fin_d.crc_error   = !(fs.t_ok & fs.h_ok);
    fin_d.cal_error   = fs.cal_eq;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_q <= fin_d;
    end
  end

  // output register with one skid entry
  res_t out_q, skid_q;
  logic out_valid_q;
  logic take, arrive;

  assign take   = out_valid_q & out_ready_i;
  assign arrive = en & v_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (arrive) begin
      if (!out_valid_q || take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_full_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= skid_full_q;
      skid_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (arrive) begin
      if (!out_valid_q || take) begin
        out_q <= fin_q;
      end else begin
        skid_q <= fin_q;
      end
    end else if (take && skid_full_q) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign temp_valid_o  = out_q.temp_valid;
  assign temperature_o = out_q.temperature;
  assign hum_valid_o   = out_q.hum_valid;
  assign humidity_o    = out_q.humidity;
  assign crc_error_o   = out_q.crc_error;
  assign cal_error_o   = out_q.cal_error;

  // checks
  a_hum_needs_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hum_valid_o |-> temp_valid_o && !crc_error_o && !cal_error_o)
    else $error("humidity flagged valid with a crc or calibration fault");

  a_temp_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !temp_valid_o |-> temperature_o == '0 && crc_error_o)
    else $error("temperature not cleared on crc mismatch");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> humidity_o <= HumW'(1000))
    else $error("humidity beyond clamp range");

  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !in_ready_o |=> in_ready_o)
    else $error("skid entry not drained after output beat");

endmodule

[sim/testbench.sv]
// testbench for the humidity/temperature frame converter: directed and random frames, scoreboard
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import htfc_pkg::*;

  localparam int CycleLimit    = 400000;
  localparam int DrainCycles   = 40;
  localparam int PhaseCount    = 9;
  localparam int FramesInPhase = 205;
  localparam int PrintedErrors = 50;

  typedef struct packed {
    logic [7:0] temp_msb;
    logic [7:0] temp_lsb;
    logic [7:0] temp_crc;
    logic [7:0] hum_msb;
    logic [7:0] hum_lsb;
    logic [7:0] hum_crc;
  } frame_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [7:0]        temp_msb_i;
  logic [7:0]        temp_lsb_i;
  logic [7:0]        temp_crc_i;
  logic [7:0]        hum_msb_i;
  logic [7:0]        hum_lsb_i;
  logic [7:0]        hum_crc_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              temp_valid_o;
  logic signed [TempW-1:0] temperature_o;
  logic              hum_valid_o;
  logic [HumW-1:0]   humidity_o;
  logic              crc_error_o;
  logic              cal_error_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;

  // shadow copies of the calibration words
  logic [15:0] cal_high_q = '0;
  logic [15:0] cal_low_q  = '0;

  res_t conversions_due[$];
  int   error_count = 0;
  int   cycle_count = 0;
  int   send_burst  = 0;
  int   recv_burst  = 0;
  int   stall_left  = 0;

  humidity_temp_frame_convert_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .temp_msb_i    (temp_msb_i),
    .temp_lsb_i    (temp_lsb_i),
    .temp_crc_i    (temp_crc_i),
    .hum_msb_i     (hum_msb_i),
    .hum_lsb_i     (hum_lsb_i),
    .hum_crc_i     (hum_crc_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .temp_valid_o  (temp_valid_o),
    .temperature_o (temperature_o),
    .hum_valid_o   (hum_valid_o),
    .humidity_o    (humidity_o),
    .crc_error_o   (crc_error_o),
    .cal_error_o   (cal_error_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk_i = ~clk_i;

  // bit-serial crc over the word, msb first
  function automatic logic [7:0] word_crc(input logic [15:0] w);
    logic [7:0] c;
    logic       fb;
    c = CrcInit;
    for (int i = 15; i >= 0; i--) begin
      fb = c[7] ^ w[i];
      c  = {c[6:0], 1'b0};
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

  function automatic frame_t good_frame(input logic [15:0] tword, input logic [15:0] cword);
    frame_t f;
    f.temp_msb = tword[15:8];
    f.temp_lsb = tword[7:0];
    f.temp_crc = word_crc(tword);
    f.hum_msb  = cword[15:8];
    f.hum_lsb  = cword[7:0];
    f.hum_crc  = word_crc(cword);
    return f;
  endfunction

  function automatic res_t convert_frame(input frame_t f);
    res_t        r;
    logic        t_ok;
    logic        h_ok;
    logic        cal_eq;
    logic [15:0] tw;
    longint      raw;
    longint      temp;
    longint      cap;
    longint      den;
    longint      hum;
    t_ok   = word_crc({f.temp_msb, f.temp_lsb}) == f.temp_crc;
    h_ok   = word_crc({f.hum_msb, f.hum_lsb}) == f.hum_crc;
    cal_eq = cal_high_q == cal_low_q;
    temp   = 0;
    hum    = 0;
    if (t_ok) begin
      tw   = {f.temp_msb, f.temp_lsb};
      raw  = longint'($signed(tw));
      // 400 + raw/25.6, whole sum truncated toward zero
      temp = (102400 + 10 * raw) / 256;
    end
    if (t_ok && h_ok && !cal_eq) begin
      cap = longint'({f.hum_msb, f.hum_lsb});
      den = longint'(cal_high_q) - longint'(cal_low_q);
      hum = (cap - longint'(cal_low_q)) * 600 / den + 300;
      hum = hum + 25 * (temp - 250) / 100;
      // exactly 1000 passes through unclamped
      if (hum > 1000) begin
        hum = 999;
      end else if (hum < 0) begin
        hum = 0;
      end
    end
    r.temp_valid  = t_ok;
    r.temperature = temp[TempW-1:0];
    r.hum_valid   = t_ok && h_ok && !cal_eq;
    r.humidity    = hum[HumW-1:0];
    r.crc_error   = !(t_ok && h_ok);
    r.cal_error   = cal_eq;
    return r;
  endfunction

  // idle cycles for one beat, with occasional runs of back-to-back beats
  function automatic int draw_wait(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 5);
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < PrintedErrors) begin
      $display("%0t ns: mismatch: %s", $realtime, msg);
    end
    error_count++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  task automatic check_result();
    res_t want;
    if (conversions_due.size() == 0) begin
      report_mismatch("result beat with no frame outstanding");
    end else begin
      want = conversions_due.pop_front();
      check_field("temp_valid", temp_valid_o, want.temp_valid);
      check_field("temperature", $signed(temperature_o), want.temperature);
      check_field("hum_valid", hum_valid_o, want.hum_valid);
      check_field("humidity", humidity_o, want.humidity);
      check_field("crc_error", crc_error_o, want.crc_error);
      check_field("cal_error", cal_error_o, want.cal_error);
    end
  endtask

  // result side: check each beat, then stall ready for a drawn number of cycles
  always @(posedge clk_i) begin
    int stall;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        check_result();
        stall = draw_wait(recv_burst);
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          stall_left = stall;
        end
      end else if (!out_ready_i) begin
        stall_left--;
        if (stall_left <= 0) begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // valid stays high across back-to-back beats, lowered only for a gap
  task automatic send_frame(input frame_t f);
    int gap;
    gap = draw_wait(send_burst);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    temp_msb_i <= f.temp_msb;
    temp_lsb_i <= f.temp_lsb;
    temp_crc_i <= f.temp_crc;
    hum_msb_i  <= f.hum_msb;
    hum_lsb_i  <= f.hum_lsb;
    hum_crc_i  <= f.hum_crc;
    do @(posedge clk_i); while (!in_ready_o);
    conversions_due.push_back(convert_frame(f));
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (conversions_due.size() != 0) @(posedge clk_i);
  endtask

  // write then read back over apb; only the low half is the register
  task automatic write_cal(input reg_idx_e idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom_range(0, 65535)), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == RegCalHigh) begin
      cal_high_q = value;
    end else begin
      cal_low_q = value;
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field(idx == RegCalHigh ? "cal_high readback" : "cal_low readback",
                prdata[15:0], value);
    psel    <= 1'b0;
    penable <= 1'b0;
    // psel low between transfers
    @(posedge clk_i);
  endtask

  task automatic set_calibration(input logic [15:0] high, input logic [15:0] low);
    write_cal(RegCalHigh, high);
    write_cal(RegCalLow, low);
  endtask

  // calibration words still at reset: every frame flags a calibration fault
  task automatic test_reset_calibration();
    frame_t f;
    send_frame(good_frame(16'h7FFF, 16'h0000));
    send_frame(good_frame(16'h8000, 16'hFFFF));
    send_frame(good_frame(16'hD7FF, 16'h1234));  // small negative sum truncates to zero
    f = good_frame(16'h0000, 16'h0000);
    f.temp_crc = f.temp_crc ^ 8'h80;
    send_frame(f);
    f = good_frame(16'hFFFF, 16'hFFFF);
    f.hum_crc = f.hum_crc ^ 8'h01;
    send_frame(f);
    wait_results_drained();
  endtask

  // raw temperature zero gives a correction of 37, so these land on the clamp edges
  task automatic test_humidity_bounds();
    set_calibration(16'd600, 16'd0);
    send_frame(good_frame(16'h0000, 16'd663));
    send_frame(good_frame(16'h0000, 16'd664));
    send_frame(good_frame(16'h8000, 16'd0));
    send_frame(good_frame(16'h7FFF, 16'hFFFF));
    send_frame(good_frame(16'h0100, 16'd600));
    wait_results_drained();
    set_calibration(16'd1600, 16'd1000);
    send_frame(good_frame(16'h0000, 16'd663));
    send_frame(good_frame(16'h0000, 16'd662));
    send_frame(good_frame(16'h0000, 16'd664));
    wait_results_drained();
  endtask

  task automatic test_calibration_extremes();
    frame_t f;
    set_calibration(16'd0, 16'hFFFF);
    send_frame(good_frame(16'h0000, 16'h0000));
    send_frame(good_frame(16'h0000, 16'hFFFF));
    wait_results_drained();
    set_calibration(16'hFFFF, 16'd0);
    send_frame(good_frame(16'h0000, 16'h0000));
    send_frame(good_frame(16'hFFFF, 16'hFFFF));
    wait_results_drained();
    set_calibration(16'd1234, 16'd1234);
    send_frame(good_frame(16'h0000, 16'd1234));
    f = good_frame(16'h0000, 16'd1234);
    f.temp_crc = ~f.temp_crc;
    send_frame(f);
    wait_results_drained();
  endtask

  task automatic test_random_frames();
    int          lo;
    int          hi;
    int          d;
    int          lo_c;
    int          hi_c;
    int          pick;
    logic [15:0] tword;
    logic [15:0] cword;
    frame_t      f;
    for (int phase = 0; phase < PhaseCount; phase++) begin
      lo = $urandom_range(0, 65535);
      case (phase % 6)
        0: begin
          hi = $urandom_range(0, 65535);
        end
        1: begin
          d  = $urandom_range(1, 8);
          hi = (lo + d > 65535) ? lo - d : lo + d;
        end
        2: begin
          hi = lo;
        end
        3: begin
          lo = ($urandom_range(0, 1) != 0) ? 65535 : 0;
          hi = 65535 - lo;
        end
        4: begin
          lo = $urandom_range(0, 60000);
          hi = lo + $urandom_range(300, 1200);
        end
        default: begin
          lo = $urandom_range(1000, 65535);
          hi = $urandom_range(0, lo - 1);
        end
      endcase
      set_calibration(16'(hi), 16'(lo));
      lo_c = ((lo < hi) ? lo : hi) - 200;
      hi_c = ((lo < hi) ? hi : lo) + 200;
      if (lo_c < 0) begin
        lo_c = 0;
      end
      if (hi_c > 65535) begin
        hi_c = 65535;
      end
      for (int n = 0; n < FramesInPhase; n++) begin
        if ($urandom_range(0, 9) < 7) begin
          tword = 16'($urandom_range(0, 65535));
        end else begin
          tword = 16'($urandom_range(0, 10000) - 4000);
        end
        if ($urandom_range(0, 1) != 0) begin
          cword = 16'($urandom_range(hi_c, lo_c));
        end else begin
          cword = 16'($urandom_range(0, 65535));
        end
        f    = good_frame(tword, cword);
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          f.temp_crc = f.temp_crc ^ (8'h01 << $urandom_range(0, 7));
        end else if (pick < 12) begin
          f.hum_crc = f.hum_crc ^ (8'h01 << $urandom_range(0, 7));
        end else if (pick < 15) begin
          // data corrupted after the crc was formed
          f.temp_lsb = f.temp_lsb ^ (8'h01 << $urandom_range(0, 7));
          f.hum_msb  = f.hum_msb ^ (8'h01 << $urandom_range(0, 7));
        end else if (pick < 18) begin
          f.temp_crc = 8'($urandom_range(0, 255));
          f.hum_crc  = 8'($urandom_range(0, 255));
        end
        send_frame(f);
      end
      wait_results_drained();
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    temp_msb_i  = '0;
    temp_lsb_i  = '0;
    temp_crc_i  = '0;
    hum_msb_i   = '0;
    hum_lsb_i   = '0;
    hum_crc_i   = '0;
    out_ready_i = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_calibration();
    test_humidity_bounds();
    test_calibration_extremes();
    test_random_frames();

    wait_results_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
src/htfc_pkg.sv
src/humidity_temp_frame_convert_unit.sv
sim/testbench.sv
